FILE: hw/rtl/tlpq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_pkg: shared types for the two-level priority queue
// Transaction payloads, result codes and the controller/datapath link.
// ----------------------------------------------------------------------------
package tlpq_pkg;

	localparam int unsigned DataBits  = 32;
	localparam int unsigned LevelBits = 5;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                        mode;       // 0 push, 1 pop
		logic                        to_urgent;  // push target
		logic signed [DataBits-1:0]  data_value;
	} in_item_t;

	typedef struct packed {
		status_t                     status;
		logic signed [DataBits-1:0]  popped_value;
		logic                        from_urgent;
		logic [LevelBits-1:0]        urgent_level;
		logic [LevelBits-1:0]        normal_level;
	} out_item_t;

	// Controller -> datapath, one-cycle pulses at transaction accept
	typedef struct packed {
		logic    push_urgent;
		logic    push_normal;
		logic    pop_urgent;
		logic    pop_normal;
		logic    load;        // latch result status
		status_t status;
	} tlpq_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic urgent_full;
		logic normal_full;
		logic urgent_empty;
		logic normal_empty;
	} tlpq_flags_t;

endpackage : tlpq_pkg
`default_nettype wire

FILE: hw/rtl/tlpq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_ctrl: transaction controller
// Decodes an accepted transaction into queue commands, then strobes the result.
// ----------------------------------------------------------------------------
module tlpq_ctrl
	import tlpq_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic        mode,
	input  wire logic        to_urgent,
	input  wire tlpq_flags_t flags,
	output tlpq_cmd_t        cmd,
	output logic             busy,
	output logic             done
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RESP = 2'b10
	} state_t;

	state_t state_q;
	logic   accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q == S_RESP);
	assign done   = (state_q == S_RESP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (start) state_q <= S_RESP;
				S_RESP: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd        = '0;
		cmd.status = ST_DONE;
		cmd.load   = accept;
		if (accept) begin
			priority if (!mode && to_urgent) begin
				if (flags.urgent_full) cmd.status = ST_FULL;
				else cmd.push_urgent = 1'b1;
			end else if (!mode) begin
				if (flags.normal_full) cmd.status = ST_FULL;
				else cmd.push_normal = 1'b1;
			end else if (!flags.urgent_empty) begin
				cmd.pop_urgent = 1'b1;
			end else if (!flags.normal_empty) begin
				cmd.pop_normal = 1'b1;
			end else begin
				cmd.status = ST_EMPTY;
			end
		end
	end

endmodule : tlpq_ctrl
`default_nettype wire

FILE: hw/rtl/tlpq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tlpq_dp: queue datapath
// Two ring buffers with pointers, occupancy counts and the result register.
// ----------------------------------------------------------------------------
module tlpq_dp
	import tlpq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16,
	parameter int unsigned WORD_BITS   = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire tlpq_cmd_t           cmd,
	input  wire logic [DataBits-1:0] wdata,
	output tlpq_flags_t              flags,
	output out_item_t                result
);

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PW-1:0] LastSlot = PW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FullCnt  = CW'(QUEUE_DEPTH);

	logic [WORD_BITS-1:0] urgent_mem [QUEUE_DEPTH];
	logic [WORD_BITS-1:0] normal_mem [QUEUE_DEPTH];

	logic [PW-1:0] u_head_q, u_tail_q, n_head_q, n_tail_q;
	logic [CW-1:0] u_cnt_q, n_cnt_q;

	logic [WORD_BITS-1:0] u_rdata_q, n_rdata_q;
	status_t              status_q;
	logic                 pop_u_q, pop_n_q;

	logic [WORD_BITS+DataBits-1:0]   wext;
	logic [WORD_BITS-1:0]            wword;
	logic [WORD_BITS-1:0]            rword;
	logic [WORD_BITS+DataBits-1:0]   rext;
	logic [CW+LevelBits-1:0]         u_lvl_ext, n_lvl_ext;

	function automatic logic [PW-1:0] next_slot(input logic [PW-1:0] p);
		return (p == LastSlot) ? '0 : p + PW'(1);
	endfunction

	assign wext  = {{WORD_BITS{1'b0}}, wdata};
	assign wword = wext[WORD_BITS-1:0];

	assign flags.urgent_full  = (u_cnt_q == FullCnt);
	assign flags.normal_full  = (n_cnt_q == FullCnt);
	assign flags.urgent_empty = (u_cnt_q == '0);
	assign flags.normal_empty = (n_cnt_q == '0);

	// Storage: one write port (tail) and one registered read port (head) each
	always_ff @(posedge clk) begin
		if (cmd.push_urgent) urgent_mem[u_tail_q] <= wword;
		if (cmd.pop_urgent)  u_rdata_q <= urgent_mem[u_head_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.push_normal) normal_mem[n_tail_q] <= wword;
		if (cmd.pop_normal)  n_rdata_q <= normal_mem[n_head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			u_head_q <= '0;
			u_tail_q <= '0;
			u_cnt_q  <= '0;
			n_head_q <= '0;
			n_tail_q <= '0;
			n_cnt_q  <= '0;
			status_q <= ST_DONE;
			pop_u_q  <= 1'b0;
			pop_n_q  <= 1'b0;
		end else begin
			if (cmd.push_urgent) begin
				u_tail_q <= next_slot(u_tail_q);
				u_cnt_q  <= u_cnt_q + CW'(1);
			end
			if (cmd.pop_urgent) begin
				u_head_q <= next_slot(u_head_q);
				u_cnt_q  <= u_cnt_q - CW'(1);
			end
			if (cmd.push_normal) begin
				n_tail_q <= next_slot(n_tail_q);
				n_cnt_q  <= n_cnt_q + CW'(1);
			end
			if (cmd.pop_normal) begin
				n_head_q <= next_slot(n_head_q);
				n_cnt_q  <= n_cnt_q - CW'(1);
			end
			if (cmd.load) begin
				status_q <= cmd.status;
				pop_u_q  <= cmd.pop_urgent;
				pop_n_q  <= cmd.pop_normal;
			end
		end
	end

	always_comb begin
		priority if (pop_u_q) rword = u_rdata_q;
		else if (pop_n_q)     rword = n_rdata_q;
		else                  rword = '0;
	end

	assign rext      = {{DataBits{1'b0}}, rword};
	assign u_lvl_ext = {{LevelBits{1'b0}}, u_cnt_q};
	assign n_lvl_ext = {{LevelBits{1'b0}}, n_cnt_q};

	assign result.status       = status_q;
	assign result.popped_value = rext[DataBits-1:0];
	assign result.from_urgent  = pop_u_q;
	assign result.urgent_level = u_lvl_ext[LevelBits-1:0];
	assign result.normal_level = n_lvl_ext[LevelBits-1:0];

endmodule : tlpq_dp
`default_nettype wire

FILE: hw/rtl/two_level_priority_queue_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_priority_queue_top: strict-priority dual FIFO
// Urgent and normal ring-buffer queues; pops drain urgent before normal.
//
//   channel   signals              direction  transfer
//   --------  -------------------  ---------  --------------------------------
//   command   start, busy, item    in         start && !busy at clk rise
//   result    done, result         out        done high for one cycle
//
// A transaction runs as follows: the accept edge performs the push or
// pops into the registered memory read, and the next cycle shows the result with
// done. busy is high during that result cycle, so no new command is taken
// while a result is shown; the controller's response state sets this.
// Reset (arst_n low) empties both queues; memory contents are not cleared.
// The receiver cannot stall: every result is presented exactly once.
// ----------------------------------------------------------------------------
module two_level_priority_queue_top
	import tlpq_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 16,  // entries per queue, 2..31 (levels are LevelBits wide)
	parameter int unsigned WORD_BITS   = 32   // stored bits per word
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire in_item_t item,
	output logic          done,
	output out_item_t     result
);

	tlpq_cmd_t   cmd;
	tlpq_flags_t flags;

	// Controller decides the operation from the occupancy flags
	tlpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.mode      (item.mode),
		.to_urgent (item.to_urgent),
		.flags     (flags),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done)
	);

	// Datapath owns the storage, pointers, counts and result register
	tlpq_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.WORD_BITS   (WORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.wdata  (item.data_value),
		.flags  (flags),
		.result (result)
	);

endmodule : two_level_priority_queue_top
`default_nettype wire

FILE: test/two_level_priority_queue_top_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// two_level_priority_queue_top_tb: self-checking bench for the priority FIFO
// Drives push/pop transactions with random gaps. A scoreboard model of the two
// ring queues predicts each result, and a monitor compares every done pulse
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module two_level_priority_queue_top_tb;
	import tlpq_pkg::*;

	localparam int unsigned QDEPTH    = 16;
	localparam int unsigned NUM_ITEMS = 1550;
	localparam logic        MODE_PUSH = 1'b0;
	localparam logic        MODE_POP  = 1'b1;

	// One queued stimulus entry: the transaction, the idle cycles in front of
	// it, and whether the sender first waits for all results to drain.
	typedef struct {
		in_item_t    txn;
		int unsigned gap;
		bit          drain;
	} stim_t;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      start  = 1'b0;
	in_item_t  item   = '0;
	logic      busy;
	logic      done;
	out_item_t result;

	stim_t       stim_q[$];
	out_item_t   due_results[$];
	int unsigned idle_cnt  = 0;
	int unsigned err_count = 0;

	// Scoreboard copy of both rings. Memory is not initialised; pops only ever
	// read slots that a push has written, so its start value never shows.
	logic [DataBits-1:0] urg_mem [QDEPTH];
	logic [DataBits-1:0] nrm_mem [QDEPTH];
	int unsigned urg_head = 0, urg_tail = 0, urg_count = 0;
	int unsigned nrm_head = 0, nrm_tail = 0, nrm_count = 0;

	two_level_priority_queue_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Apply one transaction to the scoreboard rings and return the result
	// that the block must report for it.
	function automatic out_item_t apply_queue_op(in_item_t op);
		out_item_t r;
		r        = '0;
		r.status = ST_DONE;
		if (op.mode == MODE_PUSH) begin
			// push into a full ring is rejected and changes nothing
			if (op.to_urgent) begin
				if (urg_count == QDEPTH) begin
					r.status = ST_FULL;
				end else begin
					urg_mem[urg_tail] = op.data_value;
					urg_tail          = (urg_tail + 1) % QDEPTH;
					urg_count++;
				end
			end else begin
				if (nrm_count == QDEPTH) begin
					r.status = ST_FULL;
				end else begin
					nrm_mem[nrm_tail] = op.data_value;
					nrm_tail          = (nrm_tail + 1) % QDEPTH;
					nrm_count++;
				end
			end
		end else begin
			// strict priority: urgent drains first, one word per pop;
			// to_urgent and data_value play no part here
			if (urg_count != 0) begin
				r.popped_value = urg_mem[urg_head];
				r.from_urgent  = 1'b1;
				urg_head       = (urg_head + 1) % QDEPTH;
				urg_count--;
			end else if (nrm_count != 0) begin
				r.popped_value = nrm_mem[nrm_head];
				nrm_head       = (nrm_head + 1) % QDEPTH;
				nrm_count--;
			end else begin
				r.status = ST_EMPTY;
			end
		end
		r.urgent_level = LevelBits'(urg_count);
		r.normal_level = LevelBits'(nrm_count);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic add_item(input logic m, input logic to_u, input logic [31:0] d,
			input int unsigned gap, input bit drain);
		stim_t s;
		s.txn.mode       = m;
		s.txn.to_urgent  = to_u;
		s.txn.data_value = d;
		s.gap            = gap;
		s.drain          = drain;
		stim_q.push_back(s);
	endtask

	// Driver: a transaction is taken at an edge with start high and busy low.
	// The prediction is made at that same edge; the next entry is loaded once
	// its idle gap (and drain hold, if flagged) has passed. start gets at most
	// one nonblocking write per edge, so back-to-back items keep it high.
	always @(posedge clk) begin : drive
		bit fire;
		bit load;
		fire = (start == 1'b1) && (busy == 1'b0);
		load = 1'b0;
		if (!arst_n) begin
			start    <= 1'b0;
			item     <= '0;
			idle_cnt <= 0;
		end else begin
			if (fire) begin
				due_results.push_back(apply_queue_op(item));
			end
			if ((fire || !start) && stim_q.size() != 0) begin
				if (idle_cnt < stim_q[0].gap) begin
					idle_cnt <= idle_cnt + 1;
				end else if (!(stim_q[0].drain && due_results.size() != 0)) begin
					load = 1'b1;
				end
			end
			if (load) begin
				item     <= stim_q[0].txn;
				start    <= 1'b1;
				idle_cnt <= 0;
				stim_q.pop_front();
			end else if (fire) begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: each done pulse is one result transaction; the receiver cannot
	// stall, so every pulse is checked against the oldest prediction.
	always @(posedge clk) begin : watch
		out_item_t exp_r;
		if (arst_n && done) begin
			if (due_results.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				exp_r = due_results.pop_front();
				if (result.status !== exp_r.status)
					report_mismatch($sformatf("status got %0d want %0d",
						result.status, exp_r.status));
				if (result.popped_value !== exp_r.popped_value)
					report_mismatch($sformatf("popped_value got %h want %h",
						result.popped_value, exp_r.popped_value));
				if (result.from_urgent !== exp_r.from_urgent)
					report_mismatch($sformatf("from_urgent got %b want %b",
						result.from_urgent, exp_r.from_urgent));
				if (result.urgent_level !== exp_r.urgent_level)
					report_mismatch($sformatf("urgent_level got %0d want %0d",
						result.urgent_level, exp_r.urgent_level));
				if (result.normal_level !== exp_r.normal_level)
					report_mismatch($sformatf("normal_level got %0d want %0d",
						result.normal_level, exp_r.normal_level));
			end
		end
	end

	// Stimulus, reset and end of run
	initial begin : stimulus
		int unsigned seg_len;
		int unsigned push_pct;
		int unsigned urg_pct;
		bit          quiet;
		bit          first_seg;
		logic [31:0] word;
		logic        m;

		// Directed: pop on empty (with junk in the ignored fields), data
		// extremes into both queues, urgent-before-normal ordering, and a
		// second empty pop once everything is drained.
		add_item(MODE_POP,  1'b1, 32'hFFFF_FFFF, 0, 1'b0);
		add_item(MODE_PUSH, 1'b0, 32'h8000_0000, 0, 1'b0);
		add_item(MODE_PUSH, 1'b1, 32'h7FFF_FFFF, 0, 1'b0);
		add_item(MODE_PUSH, 1'b0, 32'h0000_0000, 3, 1'b0);
		add_item(MODE_PUSH, 1'b1, 32'hFFFF_FFFF, 0, 1'b0);
		add_item(MODE_PUSH, 1'b1, 32'h0000_0001, 1, 1'b0);
		add_item(MODE_POP,  1'b0, 32'h1234_5678, 0, 1'b0);  // urgent first
		add_item(MODE_PUSH, 1'b0, 32'hA5A5_5A5A, 0, 1'b0);
		add_item(MODE_POP,  1'b0, 32'h0000_0000, 0, 1'b0);
		add_item(MODE_POP,  1'b1, 32'h0000_0000, 2, 1'b0);
		add_item(MODE_POP,  1'b0, 32'hDEAD_BEEF, 0, 1'b0);  // now normal
		add_item(MODE_POP,  1'b1, 32'h0000_0000, 0, 1'b0);
		add_item(MODE_POP,  1'b0, 32'h0000_0000, 0, 1'b0);
		add_item(MODE_POP,  1'b0, 32'hFFFF_FFFF, 0, 1'b0);  // both empty again

		// Random: segments with their own push/pop mix and queue bias. Push-
		// heavy runs fill the rings into rejection, pop-heavy runs drain them
		// to empty. Some segments idle randomly, others run back to back; some
		// start by holding off until every result is back.
		first_seg = 1'b1;
		while (stim_q.size() < NUM_ITEMS) begin
			seg_len = $urandom_range(20, 80);
			case ($urandom_range(0, 2))
				0:       push_pct = 90;
				1:       push_pct = 50;
				default: push_pct = 12;
			endcase
			urg_pct = $urandom_range(0, 100);
			quiet   = ($urandom_range(0, 2) == 0);
			for (int i = 0; i < seg_len; i++) begin
				m = ($urandom_range(0, 99) < push_pct) ? MODE_PUSH : MODE_POP;
				case ($urandom_range(0, 7))
					0:       word = 32'h0000_0000;
					1:       word = 32'h7FFF_FFFF;
					2:       word = 32'h8000_0000;
					3:       word = 32'hFFFF_FFFF;
					default: word = $urandom;
				endcase
				add_item(m, ($urandom_range(0, 99) < urg_pct), word,
					quiet ? 0 : $urandom_range(0, 15),
					(i == 0) && (first_seg || $urandom_range(0, 3) == 0));
			end
			first_seg = 1'b0;
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || start || due_results.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		if (err_count == 0) begin
			$display("two_level_priority_queue_top_tb OK");
		end else begin
			$display("two_level_priority_queue_top_tb NOT OK");
		end
		$finish;
	end

	// Watchdog: a slow correct run needs well under a tenth of this.
	initial begin : watchdog
		#2000000;
		$display("two_level_priority_queue_top_tb NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
